@@ src/mfb_pkg.sv @@
// shared types and constants for the one-bit frame store with rectangle fill
`timescale 1ns / 1ps

package mfb_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW    = 12;
  localparam logic [7:0]  FILL_BYTE   = 8'hff;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } mfb_cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ROW,
    ST_READ,
    ST_WRITE,
    ST_CLEAR,
    ST_DONE
  } mfb_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  x_start;
    logic [8:0]  y_start;
    logic [7:0]  rect_width;
    logic [8:0]  rect_height;
    logic        color_nonzero;
    logic [11:0] byte_address;
  } mfb_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_byte;
  } mfb_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic row_load;
    logic row_step;
    logic byte_step;
    logic mem_rd_fill;
    logic mem_rd_addr;
    logic mem_wr;
    logic clr_step;
    logic load_rsp;
  } mfb_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       bounds_ok;
    logic       empty;
    logic       read_ok;
    logic       drop;
    logic       last_byte;
    logic       last_row;
    logic       clr_last;
    logic       out_free;
  } mfb_sts_t;

endpackage

@@ src/mfb_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps

module mfb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mfb_ctrl.sv @@
// command sequencer for the frame store
`timescale 1ns / 1ps

module mfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mfb_pkg::mfb_sts_t sts_i,
  output mfb_pkg::mfb_ctl_t ctl_o
);
  import mfb_pkg::*;

  mfb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_FILL: begin
            if (sts_i.bounds_ok && !sts_i.empty) state_d = ST_ROW;
            else state_d = ST_DONE;
          end
          CMD_CLEAR: state_d = ST_CLEAR;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_ROW: state_d = ST_READ;
      ST_READ, ST_WRITE: begin
        if (state_q == ST_READ && !sts_i.drop) begin
          state_d = ST_WRITE;
        end else if (!sts_i.last_byte) begin
          state_d = ST_READ;
        end else if (sts_i.last_row) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ROW;
        end
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: ctl_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.accept = in_valid_i;
      end
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_FILL: ctl_o.setup       = sts_i.bounds_ok && !sts_i.empty;
          CMD_READ: ctl_o.mem_rd_addr = sts_i.read_ok;
          default:  ctl_o.setup       = 1'b0;
        endcase
      end
      ST_ROW: ctl_o.row_load = 1'b1;
      ST_READ, ST_WRITE: begin
        if (state_q == ST_READ && !sts_i.drop) begin
          ctl_o.mem_rd_fill = 1'b1;
        end else begin
          ctl_o.mem_wr    = (state_q == ST_WRITE);
          ctl_o.byte_step = !sts_i.last_byte;
          ctl_o.row_step  = sts_i.last_byte && !sts_i.last_row;
        end
      end
      ST_CLEAR: ctl_o.clr_step = 1'b1;
      ST_DONE:  ctl_o.load_rsp = sts_i.out_free;
      default:  ctl_o = '0;
    endcase
  end

  // a write always follows the read of the same byte
  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q) == ST_READ)
    else $error("write without preceding read");

  // no response load while the output register is still held
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_rsp |-> sts_i.out_free)
    else $error("response loaded over a pending one");

  // a fill walk only starts from a decoded, in-bounds, nonempty fill
  a_walk_from_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW && $past(state_q) == ST_DECODE) |-> $past(ctl_o.setup))
    else $error("fill walk entered without setup");

endmodule

@@ src/mfb_datapath.sv @@
// request registers, fill walk counters, byte masking and the frame store
`timescale 1ns / 1ps

module mfb_datapath #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfb_pkg::mfb_req_t in_req_i,
  input  mfb_pkg::mfb_ctl_t ctl_i,
  output mfb_pkg::mfb_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfb_pkg::mfb_rsp_t out_rsp_o
);
  import mfb_pkg::*;

  localparam int unsigned USED_BITS      = WIDTH_PIXELS * HEIGHT_PIXELS;
  localparam int unsigned USED_BYTES_RAW = (USED_BITS + 7) / 8;
  localparam int unsigned USED_BYTES     =
    (USED_BYTES_RAW < STORE_DEPTH) ? USED_BYTES_RAW : STORE_DEPTH;
  localparam int unsigned BIT_W  = $clog2(USED_BITS) + 1;
  localparam int unsigned BYTE_W = BIT_W - 3;

  mfb_req_t              req_q;
  logic [BIT_W-1:0]      bit_base_q;
  logic [8:0]            rows_left_q;
  logic [BYTE_W-1:0]     byte_q;
  logic [STORE_AW-1:0]   clr_cnt_q;
  logic                  out_valid_q;
  mfb_rsp_t              rsp_q;

  logic [17:0]           base_calc;
  logic [BIT_W-1:0]      end_bit;
  logic [BYTE_W-1:0]     start_byte;
  logic [BYTE_W-1:0]     end_byte;
  logic [31:0]           byte_ext;
  logic [2:0]            lo_off;
  logic [2:0]            hi_off;
  logic [7:0]            mask;
  logic [7:0]            rdata;
  logic [7:0]            merged;
  logic                  mem_we;
  logic                  mem_re;
  logic [STORE_AW-1:0]   mem_addr;
  logic [7:0]            mem_wdata;
  mfb_rsp_t              rsp_d;

  // pixel geometry of the current row segment
  assign base_calc  = 18'(req_q.y_start) * 18'(WIDTH_PIXELS) + 18'(req_q.x_start);
  assign end_bit    = bit_base_q + BIT_W'(req_q.rect_width) - BIT_W'(1);
  assign start_byte = bit_base_q[BIT_W-1:3];
  assign end_byte   = end_bit[BIT_W-1:3];
  assign byte_ext   = 32'(byte_q);

  // msb-first: pixel offset k of a byte is bit 7-k
  assign lo_off = (byte_q == start_byte) ? bit_base_q[2:0] : 3'd0;
  assign hi_off = (byte_q == end_byte) ? end_bit[2:0] : 3'd7;
  assign mask   = (8'hff >> lo_off) & (8'hff << (3'd7 - hi_off));
  assign merged = req_q.color_nonzero ? (rdata & ~mask) : (rdata | mask);

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      req_q <= in_req_i;
    end
    if (ctl_i.setup) begin
      bit_base_q  <= BIT_W'(base_calc);
      rows_left_q <= req_q.rect_height;
    end else if (ctl_i.row_step) begin
      bit_base_q  <= bit_base_q + BIT_W'(WIDTH_PIXELS);
      rows_left_q <= rows_left_q - 9'd1;
    end
    if (ctl_i.row_load) begin
      byte_q <= start_byte;
    end else if (ctl_i.byte_step) begin
      byte_q <= byte_q + BYTE_W'(1);
    end
    if (ctl_i.load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + STORE_AW'(1);
      end
      if (ctl_i.load_rsp) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status back to the sequencer
  always_comb begin
    sts_o.cmd       = req_q.cmd;
    sts_o.bounds_ok = (9'(req_q.x_start) + 9'(req_q.rect_width) <= 9'(WIDTH_PIXELS)) &&
                      (10'(req_q.y_start) + 10'(req_q.rect_height) <= 10'(HEIGHT_PIXELS));
    sts_o.empty     = (req_q.rect_width == 8'd0) || (req_q.rect_height == 9'd0);
    sts_o.read_ok   = 13'(req_q.byte_address) < 13'(USED_BYTES);
    sts_o.drop      = byte_ext >= 32'(STORE_DEPTH);
    sts_o.last_byte = byte_q == end_byte;
    sts_o.last_row  = rows_left_q == 9'd1;
    sts_o.clr_last  = &clr_cnt_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // result of the finished request
  always_comb begin
    rsp_d = '0;
    case (req_q.cmd)
      CMD_FILL:  rsp_d.status = !sts_o.bounds_ok;
      CMD_READ: begin
        rsp_d.status    = !sts_o.read_ok;
        rsp_d.read_byte = sts_o.read_ok ? rdata : 8'd0;
      end
      CMD_CLEAR: rsp_d.status = 1'b0;
      default:   rsp_d.status = 1'b1;
    endcase
  end

  // frame store port
  always_comb begin
    mem_we    = ctl_i.clr_step || ctl_i.mem_wr;
    mem_re    = ctl_i.mem_rd_fill || ctl_i.mem_rd_addr;
    mem_wdata = ctl_i.clr_step ? FILL_BYTE : merged;
    if (ctl_i.clr_step) begin
      mem_addr = clr_cnt_q;
    end else if (ctl_i.mem_rd_addr) begin
      mem_addr = req_q.byte_address;
    end else begin
      mem_addr = byte_ext[STORE_AW-1:0];
    end
  end

  mfb_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // byte writes of a fill only land inside the store
  a_no_write_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mem_wr |-> !sts_o.drop)
    else $error("fill write beyond store depth");

  // a fill write follows its own read of the same byte
  a_rmw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mem_wr |-> $past(ctl_i.mem_rd_fill) && $stable(byte_q))
    else $error("fill write without matching read");

  // every clearing pass starts at byte zero
  a_clear_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_step && !$past(ctl_i.clr_step) |-> clr_cnt_q == '0)
    else $error("clearing pass started mid-store");

endmodule

@@ src/mono_framebuffer_rect_fill.sv @@
// one-bit frame store with rectangle fill, byte read and clear
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   in_req_i  (mfb_req_t)
//   out      out_valid_o  out_stall_i  out_rsp_o (mfb_rsp_t)
//
// after reset the store is swept to 0xff, one byte a cycle; no request is taken until it ends
// fill: per row, a row load, then each byte touched is read then written,
// and a byte past the end of the store is skipped, neither read nor written
// read and rejected requests go straight to the response; clear is the same single-port sweep
// one request at a time; a finished response sits in the output register while the
// next request is taken, and a request holds in its last cycle only while that register
// is still full and out_stall_i is high
`timescale 1ns / 1ps

module mono_framebuffer_rect_fill #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mfb_pkg::mfb_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfb_pkg::mfb_rsp_t out_rsp_o
);
  import mfb_pkg::*;

  mfb_ctl_t ctl;
  mfb_sts_t sts;

  mfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mfb_datapath #(
    .WIDTH_PIXELS  (WIDTH_PIXELS),
    .HEIGHT_PIXELS (HEIGHT_PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
